// ===== src/bre_pkg.sv =====
// ----------------------------------------------------------------------------
// bre_pkg: shared types and constants for the bi-Rastrigin objective evaluator
// Fixed-point widths, register indexes, reset values and the cosine ROM
// builder used by the accumulator front end.
// ----------------------------------------------------------------------------
package bre_pkg;

    localparam int COS_TABLE_DEPTH = 1024;
    localparam int COS_W           = 25;                          // Q1.24, value <= 1.0
    localparam int COS_IDX_W       = $clog2(COS_TABLE_DEPTH + 1);
    localparam int PHASE_PROD_W    = 22 + COS_IDX_W;

    localparam longint PI_HALF_Q30 = 64'sd1686629713;
    localparam longint ONE30       = 64'sd1 << 30;
    localparam longint TAYLOR_DIV [0:6] = '{182, 132, 90, 56, 30, 12, 2};

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CENTRE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_CENTRE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FUNNEL_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_WEIGHT = 3'd4;

    localparam int CFG_DATA_W = 48;

    localparam logic signed [31:0] RST_FIRST_CENTRE  = 32'sd41943040;
    localparam logic signed [31:0] RST_SECOND_CENTRE = -32'sd40727800;
    localparam logic [24:0]        RST_FUNNEL_SCALE  = 25'd14946600;
    localparam logic [47:0]        RST_DEPTH_OFFSET  = 48'd16777216;
    localparam logic [31:0]        RST_LINEAR_WEIGHT = 32'd167772160;

    typedef struct packed {
        logic signed [31:0] first_centre;
        logic signed [31:0] second_centre;
        logic [24:0]        funnel_scale;
        logic [47:0]        depth_offset;
        logic [31:0]        linear_weight;
    } bre_cfg_t;

    // Final sums of one vector, handed from the front end to the combiner
    typedef struct packed {
        logic [46:0]        near_sum;
        logic [46:0]        far_sum;
        logic [46:0]        ripple_sum;
        logic signed [47:0] coord_sum;
    } bre_sums_t;

    typedef logic [COS_W-1:0] cos_rom_t [0:COS_TABLE_DEPTH];

    // Quarter-wave cosine, Taylor series to t^14 in Q30, rounded to Q24
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        longint   t;
        longint   u;
        longint   acc;
        longint   a;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            t   = (PI_HALF_Q30 * longint'(k)) / COS_TABLE_DEPTH;
            u   = (t * t) >>> 30;
            acc = ONE30;
            for (int j = 0; j < 7; j++) begin
                a   = (acc < 0) ? 64'sd0 : acc;
                acc = ONE30 - (((u * a) >>> 30) / TAYLOR_DIV[j]);
            end
            if (acc < 0) acc = 0;
            if (acc > ONE30) acc = ONE30;
            rom[k] = COS_W'((acc + 32) >>> 6);
        end
        return rom;
    endfunction

endpackage

// ===== src/bi_rastrigin_objective_eval.sv =====
// ----------------------------------------------------------------------------
// bi_rastrigin_objective_eval: streaming bi-Rastrigin objective
// One coordinate per beat; the objective comes out after the last coordinate.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_coordinate (Q8.24), s_last
//   m_       out  m_valid/m_ready    m_objective (Q24.24, saturated)
//   cfg_     in   cfg_wr_en          cfg_index, cfg_wr_data
//
// One coordinate accepted per cycle while s_ready is high. A result becomes
// valid once its last beat has been accepted into the term register and has
// passed the square stage, the accumulate step and four combine stages.
// Reset clears the sums, all valid flags and loads the default registers.
// A stalled m_ side backs up the four combine stages only; the front keeps
// taking beats until a last beat finds the hand-off register still full.
// ----------------------------------------------------------------------------
module bi_rastrigin_objective_eval
    import bre_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_coordinate,
    input  logic                  s_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [47:0]    m_objective
);

    bre_cfg_t  cfg_reg;
    logic      snap_valid, snap_ready;
    bre_sums_t snap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_centre  <= RST_FIRST_CENTRE;
            cfg_reg.second_centre <= RST_SECOND_CENTRE;
            cfg_reg.funnel_scale  <= RST_FUNNEL_SCALE;
            cfg_reg.depth_offset  <= RST_DEPTH_OFFSET;
            cfg_reg.linear_weight <= RST_LINEAR_WEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FIRST_CENTRE:  cfg_reg.first_centre  <= cfg_wr_data[31:0];
                REG_SECOND_CENTRE: cfg_reg.second_centre <= cfg_wr_data[31:0];
                REG_FUNNEL_SCALE:  cfg_reg.funnel_scale  <= cfg_wr_data[24:0];
                REG_DEPTH_OFFSET:  cfg_reg.depth_offset  <= cfg_wr_data[47:0];
                REG_LINEAR_WEIGHT: cfg_reg.linear_weight <= cfg_wr_data[31:0];
                default: ;
            endcase
        end
    end

    bre_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_coordinate (s_coordinate),
        .s_last       (s_last),
        .snap_valid   (snap_valid),
        .snap_ready   (snap_ready),
        .snap         (snap)
    );

    bre_combine u_combine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .snap        (snap),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_objective (m_objective)
    );

endmodule

// ===== src/bre_front.sv =====
// ----------------------------------------------------------------------------
// bre_front: per-coordinate terms and running sums
// Two stages form the squared distances and the table cosine, the third
// folds them into four saturating sums and hands the totals on at the last beat.
// ----------------------------------------------------------------------------
module bre_front
    import bre_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  bre_cfg_t           cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_coordinate,
    input  logic               s_last,
    output logic               snap_valid,
    input  logic               snap_ready,
    output bre_sums_t          snap
);

    localparam cos_rom_t COS_ROM = build_cos_rom();

    // stage A
    logic                  a_valid_reg, a_valid_next;
    logic signed [32:0]    a_d0_reg, a_d1_reg;
    logic signed [31:0]    a_x_reg;
    logic                  a_last_reg;
    logic [COS_IDX_W-1:0]  a_addr_reg;
    logic                  a_neg_reg;

    // stage B
    logic                  b_valid_reg, b_valid_next;
    logic [63:0]           b_sq0_reg, b_sq1_reg;
    logic [COS_W-1:0]      b_cos_reg;
    logic                  b_neg_reg;
    logic signed [31:0]    b_x_reg;
    logic                  b_last_reg;

    // sums
    logic [46:0]           near_reg, far_reg, ripple_reg;
    logic signed [47:0]    coord_reg;
    bre_sums_t             snap_reg;
    logic                  snap_valid_reg, snap_valid_next;

    logic                  s_fire, a_free, b_free, b_fire, snap_free;
    logic signed [32:0]    d0, d1;
    logic [23:0]           phase;
    logic [PHASE_PROD_W-1:0] phase_prod;
    logic [COS_IDX_W-1:0]  idx, idx_c, addr;
    logic [32:0]           mag0_w, mag1_w;
    logic [64:0]           sq0_rnd, sq1_rnd;
    logic [25:0]           ripple_term;
    bre_sums_t             sums_new;

    function automatic logic [46:0] sat_add_u(input logic [46:0] acc, input logic [46:0] inc);
        logic [47:0] s;
        s = {1'b0, acc} + {1'b0, inc};
        return s[47] ? {47{1'b1}} : s[46:0];
    endfunction

    // ---- input side ----
    assign snap_free = !snap_valid_reg || snap_ready;
    assign b_fire    = b_valid_reg && (!b_last_reg || snap_free);
    assign b_free    = !b_valid_reg || b_fire;
    assign a_free    = !a_valid_reg || b_free;
    assign s_ready   = a_free;
    assign s_fire    = s_valid && a_free;

    always_comb begin
        d0    = {s_coordinate[31], s_coordinate} - {cfg.first_centre[31], cfg.first_centre};
        d1    = {s_coordinate[31], s_coordinate} - {cfg.second_centre[31], cfg.second_centre};
        // fractional phase of x - mu0, top two bits pick the quadrant
        phase = s_coordinate[23:0] - cfg.first_centre[23:0];
        phase_prod = PHASE_PROD_W'(phase[21:0]) * PHASE_PROD_W'(COS_TABLE_DEPTH);
        idx   = phase_prod[PHASE_PROD_W-1:22];
        idx_c = COS_IDX_W'(COS_TABLE_DEPTH) - idx;
        addr  = phase[22] ? idx_c : idx;
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        if (a_free) begin
            a_valid_next = s_fire;
        end
        b_valid_next = b_valid_reg;
        if (b_free) begin
            b_valid_next = a_valid_reg;
        end
        snap_valid_next = snap_valid_reg;
        if (b_fire && b_last_reg) begin
            snap_valid_next = 1'b1;
        end else if (snap_ready) begin
            snap_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            snap_valid_reg <= 1'b0;
        end else begin
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= b_valid_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_d0_reg   <= d0;
            a_d1_reg   <= d1;
            a_x_reg    <= s_coordinate;
            a_last_reg <= s_last;
            a_addr_reg <= addr;
            a_neg_reg  <= phase[23] ^ phase[22];
        end
    end

    // ---- stage B: squares and ROM read ----
    always_comb begin
        mag0_w = a_d0_reg[32] ? 33'(-a_d0_reg) : 33'(a_d0_reg);
        mag1_w = a_d1_reg[32] ? 33'(-a_d1_reg) : 33'(a_d1_reg);
    end

    always_ff @(posedge aclk) begin
        if (b_free) begin
            b_sq0_reg  <= mag0_w[31:0] * mag0_w[31:0];
            b_sq1_reg  <= mag1_w[31:0] * mag1_w[31:0];
            b_cos_reg  <= COS_ROM[a_addr_reg];
            b_neg_reg  <= a_neg_reg;
            b_x_reg    <= a_x_reg;
            b_last_reg <= a_last_reg;
        end
    end

    // ---- accumulate ----
    always_comb begin
        logic signed [48:0] coord_w;
        sq0_rnd = {1'b0, b_sq0_reg} + 65'(1 << 23);
        sq1_rnd = {1'b0, b_sq1_reg} + 65'(1 << 23);
        // 1 - cos, never negative
        ripple_term = b_neg_reg ? (26'(1 << 24) + 26'(b_cos_reg))
                                : (26'(1 << 24) - 26'(b_cos_reg));
        sums_new.near_sum   = sat_add_u(near_reg, 47'(sq0_rnd[64:24]));
        sums_new.far_sum    = sat_add_u(far_reg, 47'(sq1_rnd[64:24]));
        sums_new.ripple_sum = sat_add_u(ripple_reg, 47'(ripple_term));
        coord_w = 49'(coord_reg) + 49'(b_x_reg);
        if (coord_w[48] != coord_w[47]) begin
            sums_new.coord_sum = coord_w[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            sums_new.coord_sum = coord_w[47:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg   <= '0;
            far_reg    <= '0;
            ripple_reg <= '0;
            coord_reg  <= '0;
        end else if (b_fire) begin
            if (b_last_reg) begin
                near_reg   <= '0;
                far_reg    <= '0;
                ripple_reg <= '0;
                coord_reg  <= '0;
            end else begin
                near_reg   <= sums_new.near_sum;
                far_reg    <= sums_new.far_sum;
                ripple_reg <= sums_new.ripple_sum;
                coord_reg  <= sums_new.coord_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire && b_last_reg) begin
            snap_reg <= sums_new;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// ===== src/bre_combine.sv =====
// ----------------------------------------------------------------------------
// bre_combine: final objective from the four sums
// Split products, funnel minimum, ripple and linear terms, saturated sum.
// Four stages, each holding its beat until the next one frees up.
// ----------------------------------------------------------------------------
module bre_combine
    import bre_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  bre_cfg_t           cfg,
    input  logic               snap_valid,
    output logic               snap_ready,
    input  bre_sums_t          snap,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_objective
);

    localparam logic signed [57:0] OBJ_MAX = 58'sd140737488355327;
    localparam logic signed [57:0] OBJ_MIN = -58'sd140737488355328;

    // stage D: partial products
    logic               d_valid_reg, d_valid_next;
    logic [47:0]        d_fh_reg;
    logic [48:0]        d_fl_reg;
    logic [55:0]        d_lh_reg, d_ll_reg;
    logic [46:0]        d_near_reg, d_ripple_reg;
    logic               d_neg_reg;

    // stage E: assembled terms
    logic               e_valid_reg, e_valid_next;
    logic [49:0]        e_far_reg;
    logic [56:0]        e_t3_reg;
    logic [50:0]        e_t2_reg;
    logic [46:0]        e_near_reg;
    logic               e_neg_reg;

    // stage F
    logic               f_valid_reg, f_valid_next;
    logic [46:0]        f_t1_reg;
    logic signed [57:0] f_t23_reg;

    logic               m_valid_reg, m_valid_next;
    logic signed [47:0] m_objective_reg;

    logic               d_free, e_free, f_free, m_free;
    logic [47:0]        coord_mag;
    logic [49:0]        far_term;
    logic [56:0]        t3;
    logic [50:0]        t2;
    logic signed [57:0] total;

    assign m_free     = !m_valid_reg || m_ready;
    assign f_free     = !f_valid_reg || m_free;
    assign e_free     = !e_valid_reg || f_free;
    assign d_free     = !d_valid_reg || e_free;
    assign snap_ready = d_free;

    always_comb begin
        d_valid_next = d_free ? snap_valid  : d_valid_reg;
        e_valid_next = e_free ? d_valid_reg : e_valid_reg;
        f_valid_next = f_free ? e_valid_reg : f_valid_reg;
        m_valid_next = m_free ? f_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            d_valid_reg <= d_valid_next;
            e_valid_reg <= e_valid_next;
            f_valid_reg <= f_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // magnitude first so the linear product truncates toward zero
    assign coord_mag = snap.coord_sum[47] ? (~snap.coord_sum + 48'd1) : snap.coord_sum;

    always_ff @(posedge aclk) begin
        if (d_free) begin
            d_fh_reg     <= 48'(cfg.funnel_scale) * 48'(snap.far_sum[46:24]);
            d_fl_reg     <= 49'(cfg.funnel_scale) * 49'(snap.far_sum[23:0]);
            d_lh_reg     <= 56'(cfg.linear_weight) * 56'(coord_mag[47:24]);
            d_ll_reg     <= 56'(cfg.linear_weight) * 56'(coord_mag[23:0]);
            d_near_reg   <= snap.near_sum;
            d_ripple_reg <= snap.ripple_sum;
            d_neg_reg    <= snap.coord_sum[47];
        end
    end

    always_comb begin
        far_term = 50'(cfg.depth_offset) + 50'(d_fh_reg) + 50'(d_fl_reg[48:24]);
        t3       = 57'(d_lh_reg) + 57'(d_ll_reg[55:24]);
        t2       = (51'(d_ripple_reg) << 3) + (51'(d_ripple_reg) << 1);
    end

    always_ff @(posedge aclk) begin
        if (e_free) begin
            e_far_reg  <= far_term;
            e_t3_reg   <= t3;
            e_t2_reg   <= t2;
            e_near_reg <= d_near_reg;
            e_neg_reg  <= d_neg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_free) begin
            f_t1_reg  <= (50'(e_near_reg) < e_far_reg) ? e_near_reg : e_far_reg[46:0];
            f_t23_reg <= e_neg_reg ? ($signed(58'(e_t2_reg)) - $signed(58'(e_t3_reg)))
                                   : ($signed(58'(e_t2_reg)) + $signed(58'(e_t3_reg)));
        end
    end

    assign total = $signed(58'(f_t1_reg)) + f_t23_reg;

    always_ff @(posedge aclk) begin
        if (m_free) begin
            if (total > OBJ_MAX) begin
                m_objective_reg <= OBJ_MAX[47:0];
            end else if (total < OBJ_MIN) begin
                m_objective_reg <= OBJ_MIN[47:0];
            end else begin
                m_objective_reg <= total[47:0];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_objective = m_objective_reg;

endmodule
